// File: src/chp_pkg.sv
// Shared types and constants for the conserved-to-primitive hydro core.
// No dependencies; used by the top level and the testbench.
`default_nettype none

package chp_pkg;

    localparam int FLOOR_W   = 31;
    localparam int GM1_W     = 18;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 31;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DENSITY_FLOOR  = 2'd0,
        CFG_PRESSURE_FLOOR = 2'd1,
        CFG_GAMMA_M1       = 2'd2,
        CFG_UNUSED         = 2'd3
    } cfg_idx_t;

    localparam logic [FLOOR_W-1:0] DENSITY_FLOOR_RST  = 31'd1;
    localparam logic [FLOOR_W-1:0] PRESSURE_FLOOR_RST = 31'd1;
    localparam logic [GM1_W-1:0]   GAMMA_M1_RST       = 18'd26214;

endpackage

`default_nettype wire

// File: src/cons_to_prim_adiabatic_hydro_core.sv
// Conserved-to-primitive conversion for adiabatic hydrodynamics, one cell per transaction.
// Depends on chp_pkg and chp_div.
//
// Usage:
//   Input channel (in_valid/in_ready) carries density, three momenta and total
//   energy of one cell; output channel (out_valid/out_ready) returns the
//   floored density, velocities, pressure, corrected energy and floor flags.
//   Configuration: cfg_write with cfg_index/cfg_data sets density floor (0),
//   pressure floor (1) and gamma minus one (2); write only while idle.
//   Throughput: one transaction per cycle unless the output stalls. Each cell
//   passes through the input stages, the bit-per-stage divider pipelines for
//   the velocities, kinetic energy and floor-over-gamma quotient, and the post stages.
//   Reset clears all valid bits and loads the default register values.
//   When the receiver stalls the whole pipeline holds; in_ready drops only
//   while a result waits at the output and out_ready is low.
`default_nettype none

module cons_to_prim_adiabatic_hydro_core #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [chp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [chp_pkg::CFG_DAT_W-1:0]   cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic signed [WORD_BITS-1:0]     density,
    input  wire logic signed [WORD_BITS-1:0]     momentum_x,
    input  wire logic signed [WORD_BITS-1:0]     momentum_y,
    input  wire logic signed [WORD_BITS-1:0]     momentum_z,
    input  wire logic signed [WORD_BITS-1:0]     total_energy,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [WORD_BITS-2:0]                 prim_density,
    output logic signed [WORD_BITS-1:0]          velocity_x,
    output logic signed [WORD_BITS-1:0]          velocity_y,
    output logic signed [WORD_BITS-1:0]          velocity_z,
    output logic [WORD_BITS-2:0]                 pressure,
    output logic signed [WORD_BITS-1:0]          corrected_energy,
    output logic                                 density_floored,
    output logic                                 pressure_floored
);

    localparam int W      = WORD_BITS;
    localparam int F      = FRAC_BITS;
    localparam int FW     = chp_pkg::FLOOR_W;
    localparam int GW     = chp_pkg::GM1_W;
    localparam int RHO_W  = (W - 1 > FW) ? W - 1 : FW;
    localparam int EXT_W  = RHO_W + 1;
    localparam int DEN_W  = RHO_W + 1;
    localparam int SQ_W   = 2 * W + 2;
    localparam int VN_W   = W + F;
    localparam int FN_W   = FW + F;
    localparam int DIV_A  = (VN_W > SQ_W) ? VN_W : SQ_W;
    localparam int DIV_W  = (DIV_A > FN_W) ? DIV_A : FN_W;
    localparam int SIDE_W = 3 + W + RHO_W + 1;
    localparam int NS     = DIV_W + 6;
    localparam int PR_W   = W + GW;

    localparam logic [DIV_W-1:0] WMAX_D = DIV_W'((DIV_W + 1)'(1) << (W - 1)) - DIV_W'(1);
    localparam logic [EXT_W-1:0] WMAX_X = EXT_W'((EXT_W + 1)'(1) << (W - 1)) - EXT_W'(1);
    localparam logic [PR_W-F-1:0] WMAX_P = (PR_W - F)'(WMAX_X);

    // configuration
    logic [FW-1:0] dfloor_reg;
    logic [FW-1:0] pfloor_reg;
    logic [GW-1:0] gm1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dfloor_reg <= chp_pkg::DENSITY_FLOOR_RST;
            pfloor_reg <= chp_pkg::PRESSURE_FLOOR_RST;
            gm1_reg    <= chp_pkg::GAMMA_M1_RST;
        end
        else if (cfg_write)
        begin
            unique case (chp_pkg::cfg_idx_t'(cfg_index))
                chp_pkg::CFG_DENSITY_FLOOR:  dfloor_reg <= cfg_data[FW-1:0];
                chp_pkg::CFG_PRESSURE_FLOOR: pfloor_reg <= cfg_data[FW-1:0];
                chp_pkg::CFG_GAMMA_M1:       gm1_reg    <= cfg_data[GW-1:0];
                default: ;
            endcase
        end
    end

    logic [FW-1:0]    dfl_eff;
    logic [EXT_W-1:0] dfl_sat;
    logic [EXT_W-1:0] pfl_sat;

    assign dfl_eff = (dfloor_reg == '0) ? FW'(1) : dfloor_reg;
    assign dfl_sat = (EXT_W'(dfl_eff) > WMAX_X) ? WMAX_X : EXT_W'(dfl_eff);
    assign pfl_sat = (EXT_W'(pfloor_reg) > WMAX_X) ? WMAX_X : EXT_W'(pfloor_reg);

    // pipeline control
    logic [NS-1:0] vld_reg;
    logic          adv;

    assign adv       = !vld_reg[NS-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NS-2:0], in_valid};
    end

    // stage 1: density floor, magnitudes
    logic signed [W-1:0]       mom [3];
    logic signed [RHO_W+1:0]   d_x;
    logic signed [RHO_W+1:0]   dfl_x;
    logic                      d_gt;

    assign mom[0] = momentum_x;
    assign mom[1] = momentum_y;
    assign mom[2] = momentum_z;
    assign d_x    = (RHO_W + 2)'(density);
    assign dfl_x  = signed'((RHO_W + 2)'(dfl_eff));
    assign d_gt   = d_x > dfl_x;

    logic [RHO_W-1:0]    s1_rho_reg, s2_rho_reg, s3_rho_reg;
    logic                s1_dflag_reg, s2_dflag_reg, s3_dflag_reg;
    logic [W-1:0]        s1_mag_reg [3];
    logic [W-1:0]        s2_mag_reg [3];
    logic [W-1:0]        s3_mag_reg [3];
    logic [2:0]          s1_neg_reg, s2_neg_reg, s3_neg_reg;
    logic signed [W-1:0] s1_e_reg, s2_e_reg, s3_e_reg;
    logic [2*W-1:0]      s2_sq_reg [3];
    logic [SQ_W-1:0]     s3_sum_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_rho_reg   <= d_gt ? d_x[RHO_W-1:0] : RHO_W'(dfl_eff);
            s1_dflag_reg <= !d_gt;
            s1_e_reg     <= total_energy;
            for (int i = 0; i < 3; i++)
            begin
                s1_neg_reg[i] <= mom[i][W-1];
                s1_mag_reg[i] <= mom[i][W-1] ? W'(-mom[i]) : W'(mom[i]);
            end

            for (int i = 0; i < 3; i++)
                s2_sq_reg[i] <= (2 * W)'(s1_mag_reg[i]) * (2 * W)'(s1_mag_reg[i]);
            s2_mag_reg   <= s1_mag_reg;
            s2_neg_reg   <= s1_neg_reg;
            s2_rho_reg   <= s1_rho_reg;
            s2_dflag_reg <= s1_dflag_reg;
            s2_e_reg     <= s1_e_reg;

            s3_sum_reg   <= SQ_W'(s2_sq_reg[0]) + SQ_W'(s2_sq_reg[1]) + SQ_W'(s2_sq_reg[2]);
            s3_mag_reg   <= s2_mag_reg;
            s3_neg_reg   <= s2_neg_reg;
            s3_rho_reg   <= s2_rho_reg;
            s3_dflag_reg <= s2_dflag_reg;
            s3_e_reg     <= s2_e_reg;
        end
    end

    // divider pipelines
    logic [DIV_W-1:0] qv [3];
    logic [DIV_W-1:0] qk;
    logic [DIV_W-1:0] qf;

    genvar k;
    generate
        for (k = 0; k < 3; k++)
        begin : g_vel
            chp_div #(
                .NUM_W (DIV_W),
                .DEN_W (DEN_W)
            ) u_div_v (
                .clk (clk),
                .en  (adv),
                .num (DIV_W'({s3_mag_reg[k], F'(0)})),
                .den (DEN_W'(s3_rho_reg)),
                .quo (qv[k])
            );
        end
    endgenerate

    chp_div #(
        .NUM_W (DIV_W),
        .DEN_W (DEN_W)
    ) u_div_k (
        .clk (clk),
        .en  (adv),
        .num (DIV_W'(s3_sum_reg)),
        .den ({s3_rho_reg, 1'b0}),
        .quo (qk)
    );

    chp_div #(
        .NUM_W (DIV_W),
        .DEN_W (DEN_W)
    ) u_div_f (
        .clk (clk),
        .en  (adv),
        .num (DIV_W'({pfloor_reg, F'(0)})),
        .den (DEN_W'(gm1_reg)),
        .quo (qf)
    );

    logic [SIDE_W-1:0] side_reg [DIV_W];
    logic [2:0]          sd_neg;
    logic signed [W-1:0] sd_e;
    logic [RHO_W-1:0]    sd_rho;
    logic                sd_dflag;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= {s3_neg_reg, s3_e_reg, s3_rho_reg, s3_dflag_reg};
            for (int i = 1; i < DIV_W; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    assign {sd_neg, sd_e, sd_rho, sd_dflag} = side_reg[DIV_W-1];

    // post stage 1: saturate quotients, internal energy
    logic signed [W-1:0] vel_c [3];
    logic [W-2:0]        ke_c;
    logic [W-2:0]        qf_c;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (qv[i] > WMAX_D)
                vel_c[i] = sd_neg[i] ? {1'b1, (W - 1)'(0)} : {1'b0, {(W - 1){1'b1}}};
            else if (sd_neg[i])
                vel_c[i] = -signed'(qv[i][W-1:0]);
            else
                vel_c[i] = signed'(qv[i][W-1:0]);
        end
        ke_c = (qk > WMAX_D) ? WMAX_D[W-2:0] : qk[W-2:0];
        qf_c = (qf > WMAX_D) ? WMAX_D[W-2:0] : qf[W-2:0];
    end

    logic signed [W-1:0] p1_vel_reg [3];
    logic signed [W-1:0] p2_vel_reg [3];
    logic [W-2:0]        p1_ke_reg, p2_ke_reg;
    logic [W-2:0]        p1_qf_reg, p2_qf_reg;
    logic signed [W:0]   p1_eint_reg;
    logic signed [W-1:0] p1_e_reg, p2_e_reg;
    logic [W-2:0]        p1_rho_reg, p2_rho_reg;
    logic                p1_dflag_reg, p2_dflag_reg;
    logic [PR_W-1:0]     p2_prod_reg;
    logic                p2_pos_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_vel_reg   <= vel_c;
            p1_ke_reg    <= ke_c;
            p1_qf_reg    <= qf_c;
            p1_eint_reg  <= (W + 1)'(sd_e) - signed'((W + 1)'(ke_c));
            p1_e_reg     <= sd_e;
            p1_rho_reg   <= (EXT_W'(sd_rho) > WMAX_X) ? WMAX_X[W-2:0] : sd_rho[W-2:0];
            p1_dflag_reg <= sd_dflag;

            p2_prod_reg  <= PR_W'(p1_eint_reg[W-1:0]) * PR_W'(gm1_reg);
            p2_pos_reg   <= p1_eint_reg > 0;
            p2_vel_reg   <= p1_vel_reg;
            p2_ke_reg    <= p1_ke_reg;
            p2_qf_reg    <= p1_qf_reg;
            p2_e_reg     <= p1_e_reg;
            p2_rho_reg   <= p1_rho_reg;
            p2_dflag_reg <= p1_dflag_reg;
        end
    end

    // post stage 3: pressure floor and energy correction
    logic [PR_W-F-1:0] pu_full;
    logic [W-2:0]      pu_sat;
    logic              pflag;
    logic [W-1:0]      esum;
    logic [W-2:0]      efix;

    assign pu_full = p2_prod_reg[PR_W-1:F];
    assign pu_sat  = (pu_full > WMAX_P) ? WMAX_X[W-2:0] : pu_full[W-2:0];
    assign pflag   = !(p2_pos_reg && (EXT_W'(pu_sat) > EXT_W'(pfloor_reg)));
    assign esum    = W'(p2_qf_reg) + W'(p2_ke_reg);
    assign efix    = esum[W-1] ? WMAX_X[W-2:0] : esum[W-2:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prim_density     <= p2_rho_reg;
            velocity_x       <= p2_vel_reg[0];
            velocity_y       <= p2_vel_reg[1];
            velocity_z       <= p2_vel_reg[2];
            pressure         <= pflag ? pfl_sat[W-2:0] : pu_sat;
            corrected_energy <= pflag ? signed'({1'b0, efix}) : p2_e_reg;
            density_floored  <= p2_dflag_reg;
            pressure_floored <= pflag;
        end
    end

    // checks
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

    a_pfloor_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pressure_floored) |-> (pressure == pfl_sat[W-2:0]))
        else $error("floored pressure differs from floor");

    a_dfloor_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && density_floored) |-> (prim_density == dfl_sat[W-2:0]))
        else $error("floored density differs from floor");

endmodule

`default_nettype wire

// File: src/chp_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// The stages advance only while en is high; depends on nothing else.
`default_nettype none

module chp_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 32
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [NUM_W-1:0] quo
);

    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] num_reg [NUM_W];
    logic [NUM_W-1:0] quo_reg [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];

    logic [DEN_W-1:0] rem_prev [NUM_W];
    logic [NUM_W-1:0] num_prev [NUM_W];
    logic [NUM_W-1:0] quo_prev [NUM_W];
    logic [DEN_W-1:0] den_prev [NUM_W];

    logic [DEN_W-1:0] rem_next [NUM_W];
    logic [NUM_W-1:0] quo_next [NUM_W];

    genvar s;
    generate
        for (s = 0; s < NUM_W; s++)
        begin : g_stage
            logic [DEN_W:0] trial;
            logic [DEN_W:0] diff;
            logic           ge;

            if (s == 0)
            begin : g_first
                assign rem_prev[s] = '0;
                assign num_prev[s] = num;
                assign quo_prev[s] = '0;
                assign den_prev[s] = den;
            end
            else
            begin : g_rest
                assign rem_prev[s] = rem_reg[s-1];
                assign num_prev[s] = num_reg[s-1];
                assign quo_prev[s] = quo_reg[s-1];
                assign den_prev[s] = den_reg[s-1];
            end

            assign trial       = {rem_prev[s], num_prev[s][NUM_W-1]};
            assign ge          = (trial >= {1'b0, den_prev[s]});
            assign diff        = trial - {1'b0, den_prev[s]};
            assign rem_next[s] = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            assign quo_next[s] = {quo_prev[s][NUM_W-2:0], ge};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= rem_next[s];
                    num_reg[s] <= {num_prev[s][NUM_W-2:0], 1'b0};
                    quo_reg[s] <= quo_next[s];
                    den_reg[s] <= den_prev[s];
                end
            end
        end
    endgenerate

    assign quo = quo_reg[NUM_W-1];

endmodule

`default_nettype wire

// File: bench/cons_to_prim_adiabatic_hydro_core_tb.sv
// Testbench for the conserved-to-primitive hydro core: directed and random cells,
// checked against an in-bench conversion model. Depends on chp_pkg and the core RTL.
`timescale 1ns / 1ps

class cell_scoreboard;
    typedef struct {
        logic [30:0] rho;
        logic signed [31:0] vx, vy, vz;
        logic [30:0] p;
        logic signed [31:0] en;
        logic dfl, pfl;
    } prim_t;

    logic [30:0] density_floor = 31'd1;
    logic [30:0] pressure_floor = 31'd1;
    logic [17:0] gamma_m1 = 18'd26214;
    prim_t pending[$];
    int errors = 0;
    int checked = 0;
    int dfl_hits = 0;
    int pfl_hits = 0;

    function longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function longint vel(longint m, longint unsigned rho);
        longint unsigned mm;
        longint unsigned q;
        mm = (m < 0) ? longint'(-m) : longint'(m);
        q = (mm << 16) / rho;
        if (q > 64'h7fffffffffffffff)
            q = 64'h7fffffffffffffff;
        return sat32(m < 0 ? -longint'(q) : longint'(q));
    endfunction

    function void note_cell(logic signed [31:0] d, logic signed [31:0] m1,
                            logic signed [31:0] m2, logic signed [31:0] m3,
                            logic signed [31:0] e);
        prim_t r;
        longint unsigned dfl, rho, a1, a2, a3, sumsq, keu, pu, em, q;
        longint ke, eint, energy;
        bit pf;
        dfl = (density_floor == 0) ? 1 : density_floor;
        if (longint'(d) > longint'(dfl))
        begin
            rho = longint'(d);
            r.dfl = 0;
        end
        else
        begin
            rho = dfl;
            r.dfl = 1;
        end
        r.vx = 32'(vel(m1, rho));
        r.vy = 32'(vel(m2, rho));
        r.vz = 32'(vel(m3, rho));
        a1 = (m1 < 0) ? -longint'(m1) : longint'(m1);
        a2 = (m2 < 0) ? -longint'(m2) : longint'(m2);
        a3 = (m3 < 0) ? -longint'(m3) : longint'(m3);
        sumsq = a1 * a1 + a2 * a2 + a3 * a3;
        keu = sumsq / (2 * rho);
        if (keu > 2147483647)
            keu = 2147483647;
        ke = longint'(keu);
        eint = longint'(e) - ke;
        pf = 1;
        pu = 0;
        if (eint > 0 && gamma_m1 != 0)
        begin
            em = eint;
            if (em > 64'hffffffffffffffff / gamma_m1)
                pu = 2147483647;
            else
            begin
                pu = (em * gamma_m1) >> 16;
                if (pu > 2147483647)
                    pu = 2147483647;
            end
            if (pu > pressure_floor)
                pf = 0;
        end
        if (pf)
        begin
            if (gamma_m1 == 0)
                q = 2147483647;
            else
            begin
                q = (longint'(pressure_floor) << 16) / gamma_m1;
                if (q > 2147483647)
                    q = 2147483647;
            end
            energy = sat32(longint'(q) + ke);
            pu = pressure_floor;
            pfl_hits++;
        end
        else
            energy = e;
        if (r.dfl)
            dfl_hits++;
        r.rho = rho[30:0];
        r.p = pu[30:0];
        r.en = energy[31:0];
        r.pfl = pf;
        pending.push_back(r);
    endfunction

    function void check_prim(prim_t a);
        prim_t x;
        bit bad;
        bad = 0;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result rho=%h", $realtime, a.rho);
            errors++;
            return;
        end
        x = pending.pop_front();
        checked++;
        if (a.rho !== x.rho)
        begin
            $display("%0t: prim_density exp %h act %h", $realtime, x.rho, a.rho);
            bad = 1;
        end
        if (a.vx !== x.vx)
        begin
            $display("%0t: velocity_x exp %h act %h", $realtime, x.vx, a.vx);
            bad = 1;
        end
        if (a.vy !== x.vy)
        begin
            $display("%0t: velocity_y exp %h act %h", $realtime, x.vy, a.vy);
            bad = 1;
        end
        if (a.vz !== x.vz)
        begin
            $display("%0t: velocity_z exp %h act %h", $realtime, x.vz, a.vz);
            bad = 1;
        end
        if (a.p !== x.p)
        begin
            $display("%0t: pressure exp %h act %h", $realtime, x.p, a.p);
            bad = 1;
        end
        if (a.en !== x.en)
        begin
            $display("%0t: corrected_energy exp %h act %h", $realtime, x.en, a.en);
            bad = 1;
        end
        if (a.dfl !== x.dfl)
        begin
            $display("%0t: density_floored exp %b act %b", $realtime, x.dfl, a.dfl);
            bad = 1;
        end
        if (a.pfl !== x.pfl)
        begin
            $display("%0t: pressure_floored exp %b act %b", $realtime, x.pfl, a.pfl);
            bad = 1;
        end
        if (bad)
            errors++;
    endfunction
endclass

module cons_to_prim_adiabatic_hydro_core_tb;

    localparam int LATENCY = 72;
    localparam int WATCHDOG = 20000;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_write = 0;
    logic [chp_pkg::CFG_IDX_W-1:0] cfg_index = chp_pkg::CFG_DENSITY_FLOOR;
    logic [chp_pkg::CFG_DAT_W-1:0] cfg_data = '0;
    logic in_valid = 0;
    logic in_ready;
    logic signed [31:0] density = 0, momentum_x = 0, momentum_y = 0;
    logic signed [31:0] momentum_z = 0, total_energy = 0;
    logic out_valid;
    logic out_ready = 0;
    logic [30:0] prim_density, pressure;
    logic signed [31:0] velocity_x, velocity_y, velocity_z, corrected_energy;
    logic density_floored, pressure_floored;

    cell_scoreboard sb = new();
    int idle_cycles = 0;
    bit long_hold = 0;

    cons_to_prim_adiabatic_hydro_core DUT (.*);

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    task automatic write_reg(chp_pkg::cfg_idx_t idx, logic [30:0] val);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 0;
        case (idx)
            chp_pkg::CFG_DENSITY_FLOOR: sb.density_floor = val;
            chp_pkg::CFG_PRESSURE_FLOOR: sb.pressure_floor = val;
            chp_pkg::CFG_GAMMA_M1: sb.gamma_m1 = val[17:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_cell(logic signed [31:0] d, logic signed [31:0] m1,
                             logic signed [31:0] m2, logic signed [31:0] m3,
                             logic signed [31:0] e);
        in_valid <= 1;
        density <= d;
        momentum_x <= m1;
        momentum_y <= m2;
        momentum_z <= m3;
        total_energy <= e;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_cell(d, m1, m2, m3, e);
    endtask

    task automatic pause_sender();
        int gap;
        gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 32'h7ffff);
            2: return -$signed({1'b0, 31'($urandom_range(0, 32'h7ffff))});
            3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return $signed(32'($urandom_range(0, 32'h3ffffff)))
                            - 32'sh1000000;
        endcase
    endfunction

    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic random_cells(int n);
        logic signed [31:0] d, e;
        for (int i = 0; i < n; i++)
        begin
            d = ($urandom_range(0, 4) == 0) ? rand_word()
                : $signed(32'($urandom_range(1, 32'h3ffffff)));
            e = rand_word();
            send_cell(d, rand_word(), rand_word(), rand_word(), e);
            if ((i % 64) < 40)
                pause_sender();
        end
        in_valid <= 0;
    endtask

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check_prim('{prim_density, velocity_x, velocity_y, velocity_z,
                            pressure, corrected_energy, density_floored,
                            pressure_floored});
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("watchdog expired");
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int phase;
        phase = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_ready <= 0;
                repeat (400) @(posedge clk);
                long_hold = 0;
            end
            phase++;
            if ((phase / 300) % 2 == 0)
                out_ready <= 1;
            else
                out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_cell(32'sh10000, 32'sh20000, -32'sh10000, 0, 32'sh80000);
        send_cell(0, 32'sh10000, 0, 0, 32'sh10000);
        send_cell(-32'sh10000, 0, 0, 0, 0);
        send_cell(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        send_cell(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_cell(1, 32'h7fffffff, 32'h80000000, 1, 32'h7fffffff);
        send_cell(32'sh10000, 0, 0, 0, -32'sh10000);
        send_cell(32'sh10000, 32'sh40000, 0, 0, 32'sh80000);
        send_cell(32'sh10000, 0, 0, 0, 1);
        send_cell(2, -1, 1, -1, 32'hffffffff);
        in_valid <= 0;
        drain();

        write_reg(chp_pkg::CFG_DENSITY_FLOOR, 31'h7fffffff);
        write_reg(chp_pkg::CFG_PRESSURE_FLOOR, 31'h7fffffff);
        write_reg(chp_pkg::CFG_GAMMA_M1, 31'd131072);
        send_cell(32'h7fffffff, 32'sh10000, 0, 0, 32'h7fffffff);
        send_cell(5, 32'h80000000, 0, 0, 0);
        in_valid <= 0;
        drain();

        write_reg(chp_pkg::CFG_DENSITY_FLOOR, 31'd0);
        write_reg(chp_pkg::CFG_PRESSURE_FLOOR, 31'd0);
        write_reg(chp_pkg::CFG_GAMMA_M1, 31'd0);
        send_cell(0, 32'sh10000, 0, 0, 32'sh10000);
        send_cell(32'sh10000, 0, 0, 0, 32'sh10000);
        send_cell(-5, 7, -7, 0, -1);
        in_valid <= 0;
        drain();
        write_reg(chp_pkg::CFG_UNUSED, 31'd5);

        write_reg(chp_pkg::CFG_DENSITY_FLOOR, 31'd1);
        write_reg(chp_pkg::CFG_PRESSURE_FLOOR, 31'd1);
        write_reg(chp_pkg::CFG_GAMMA_M1, 31'd26214);
        long_hold = 1;
        random_cells(500);
        drain();

        write_reg(chp_pkg::CFG_DENSITY_FLOOR, 31'h100);
        write_reg(chp_pkg::CFG_PRESSURE_FLOOR, 31'h800);
        write_reg(chp_pkg::CFG_GAMMA_M1, 31'd43690);
        random_cells(500);
        drain();

        write_reg(chp_pkg::CFG_DENSITY_FLOOR, 31'($urandom));
        write_reg(chp_pkg::CFG_PRESSURE_FLOOR, 31'($urandom_range(0, 32'hfffff)));
        write_reg(chp_pkg::CFG_GAMMA_M1, 31'($urandom_range(1, 131072)));
        random_cells(500);
        drain();

        $display("checked %0d cells over six register settings;", sb.checked);
        $display("%0d density floors, %0d pressure floors", sb.dfl_hits, sb.pfl_hits);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
